### rtl/rdqm_pkg.sv
// Package for the RED drop queue manager: item types, register codes and
// drop thresholds shared by the configuration block and the top level.
// Depends on nothing.
package rdqm_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 64;
    localparam int DEFAULT_TAG_BITS    = 32;

    localparam int TAG_W    = 32;   // width of the tag fields in the items
    localparam int RND_W    = 16;
    localparam int QLEN_W   = 7;
    localparam int TOTAL_W  = 32;
    localparam int CAP_W    = 7;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Register index as decoded from the word address.
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic FUNC_ARRIVAL   = 1'b0;
    localparam logic FUNC_DEPARTURE = 1'b1;

    // Drop thresholds on a 17-bit scale: drop when random_value < threshold.
    localparam logic [RND_W:0] THR_Q2 = 17'd13108;
    localparam logic [RND_W:0] THR_Q3 = 17'd32768;
    localparam logic [RND_W:0] THR_Q4 = 17'd52429;
    localparam int             ALWAYS_DROP_LEN = 5;

    typedef struct packed {
        logic             func;
        logic [TAG_W-1:0] packet_tag;
        logic [RND_W-1:0] random_value;
    } rdqm_req_t;

    typedef struct packed {
        logic               was_dropped;
        logic               was_forwarded;
        logic [TAG_W-1:0]   forwarded_tag;
        logic [QLEN_W-1:0]  queue_length;
        logic               start_service;
        logic               more_pending;
        logic [TOTAL_W-1:0] drop_total;
        logic [TOTAL_W-1:0] forward_total;
    } rdqm_rsp_t;

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic             flush;
    } rdqm_cfg_t;

endpackage

### rtl/rdqm_tag_ram.sv
// Tag storage of the queue: one write port and one read port with a
// registered read. Depends on nothing.
module rdqm_tag_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/rdqm_cfg_regs.sv
// APB configuration register for the queue capacity, with a flush pulse on
// every capacity write. Depends on rdqm_pkg.
module rdqm_cfg_regs
    import rdqm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output rdqm_cfg_t         cfg
);

    logic [CAP_W-1:0] capacity_reg;
    logic             flush_reg;
    logic             wr_cap;

    // The byte lanes below the word address are ignored.
    assign wr_cap = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            flush_reg    <= 1'b0;
        end
        else
        begin
            flush_reg <= wr_cap;
            if (wr_cap)
            begin
                capacity_reg <= pwdata[CAP_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_CAPACITY: prdata = APB_DW'(capacity_reg);
            default:      prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign cfg.capacity = capacity_reg;
    assign cfg.flush    = flush_reg;

endmodule

### rtl/red_drop_queue_manager_core.sv
// Top level of the RED drop queue manager: input register, queue state,
// admission logic and result register. Depends on rdqm_pkg, rdqm_cfg_regs
// and rdqm_tag_ram.
//
// Usage: events enter on the req channel (valid/ready), one item per event.
// An arrival (func = 0) carries a packet tag and a 16-bit random value; a
// departure (func = 1) pops the head of the queue. Every item produces exactly
// one result item on the rsp channel: drop and forward flags, the popped tag,
// the queue length after the event, the service hints and both saturating
// totals. The capacity register sits on the APB port at byte address 0; a
// write to it empties the queue but keeps the totals.
//
// An accepted item waits in the input register, where the drop decision is
// made and the tag memory is written or read; when it advances, rsp_valid
// rises as the result register loads, in step with the registered read of
// the tag memory. Throughput is one item per cycle while rsp_ready is high.
// While rsp_ready is low the result register holds its item, the input
// register holds the next one and req_ready falls only once both are full.
// Reset empties the queue, clears both totals and sets the capacity to 64; the
// tag memory is not cleared, since only written entries are ever read.
module red_drop_queue_manager_core
    import rdqm_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    parameter int TAG_BITS    = DEFAULT_TAG_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  rdqm_req_t         req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rdqm_rsp_t         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    // Compare width wide enough for the count, the capacity and the depth.
    localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
    localparam int EXT_W = 128;

    rdqm_cfg_t cfg;

    rdqm_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register.
    logic      s1_valid_reg;
    rdqm_req_t s1_item_reg;
    logic      s1_adv;

    // Queue state.
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TOTAL_W-1:0] drop_cnt_reg, drop_cnt_next;
    logic [TOTAL_W-1:0] fwd_cnt_reg, fwd_cnt_next;

    // Result register.
    logic      rsp_valid_reg;
    rdqm_rsp_t rsp_reg, rsp_next;

    // Decision terms.
    logic             is_arrival;
    logic [CMP_W-1:0] count_x;
    logic [CMP_W-1:0] cap_eff;
    logic [RND_W:0]   rnd_x;
    logic             early_drop;
    logic             full;
    logic             admit;
    logic             depart;

    logic [TAG_BITS-1:0] wr_tag;
    logic [TAG_BITS-1:0] rd_tag;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        logic [IDX_W:0] inc;
        inc = {1'b0, i} + (IDX_W+1)'(1);
        return (inc >= (IDX_W+1)'(QUEUE_DEPTH)) ? '0 : inc[IDX_W-1:0];
    endfunction

    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        is_arrival = (s1_item_reg.func == FUNC_ARRIVAL);
        count_x    = CMP_W'(count_reg);
        cap_eff    = (CMP_W'(cfg.capacity) > CMP_W'(QUEUE_DEPTH)) ?
                     CMP_W'(QUEUE_DEPTH) : CMP_W'(cfg.capacity);
        rnd_x      = {1'b0, s1_item_reg.random_value};

        // Stepped drop curve: never below two entries, always from five up.
        if (count_x >= CMP_W'(ALWAYS_DROP_LEN))
        begin
            early_drop = 1'b1;
        end
        else
        begin
            case (count_x[2:0])
                3'd2:    early_drop = (rnd_x < THR_Q2);
                3'd3:    early_drop = (rnd_x < THR_Q3);
                3'd4:    early_drop = (rnd_x < THR_Q4);
                default: early_drop = 1'b0;
            endcase
        end

        full   = (count_x >= cap_eff);
        admit  = is_arrival && !early_drop && !full;
        depart = !is_arrival && (count_reg != '0);
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        drop_cnt_next = drop_cnt_reg;
        fwd_cnt_next  = fwd_cnt_reg;

        if (is_arrival && !admit && (drop_cnt_reg != '1))
        begin
            drop_cnt_next = drop_cnt_reg + TOTAL_W'(1);
        end
        if (admit)
        begin
            tail_next  = next_idx(tail_reg);
            count_next = count_reg + CNT_W'(1);
        end
        if (depart)
        begin
            head_next  = next_idx(head_reg);
            count_next = count_reg - CNT_W'(1);
            if (fwd_cnt_reg != '1)
            begin
                fwd_cnt_next = fwd_cnt_reg + TOTAL_W'(1);
            end
        end

        rsp_next.was_dropped   = is_arrival && !admit;
        rsp_next.was_forwarded = depart;
        rsp_next.forwarded_tag = '0;    // filled from the tag memory read
        rsp_next.queue_length  = QLEN_W'(count_next);
        rsp_next.start_service = admit && (count_reg == '0);
        rsp_next.more_pending  = depart && (count_reg != CNT_W'(1));
        rsp_next.drop_total    = drop_cnt_next;
        rsp_next.forward_total = fwd_cnt_next;
    end

    assign wr_tag = TAG_BITS'(EXT_W'(s1_item_reg.packet_tag));

    rdqm_tag_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (TAG_BITS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (s1_adv && admit),
        .wr_addr (tail_reg),
        .wr_data (wr_tag),
        .rd_en   (s1_adv && depart),
        .rd_addr (head_reg),
        .rd_data (rd_tag)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            drop_cnt_reg  <= '0;
            fwd_cnt_reg   <= '0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s1_adv)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            // The user must issue a capacity write only while the block is idle; the block itself does not enforce it.
            if (cfg.flush)
            begin
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
            end
            else if (s1_adv)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            if (s1_adv)
            begin
                drop_cnt_reg <= drop_cnt_next;
                fwd_cnt_reg  <= fwd_cnt_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_item_reg <= req;
        end
        if (s1_adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb
    begin
        rsp               = rsp_reg;
        rsp.forwarded_tag = rsp_reg.was_forwarded ? TAG_W'(EXT_W'(rd_tag)) : '0;
    end

    assign rsp_valid = rsp_valid_reg;

    // The occupancy never exceeds the storage.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    // A result never both drops and forwards.
    a_drop_fwd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.was_dropped && rsp.was_forwarded))
        else $error("result both dropped and forwarded");

    // Start of service only when the arrival left exactly one entry.
    a_start_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.start_service) |-> (rsp.queue_length == QLEN_W'(1)))
        else $error("start_service with queue length other than one");

    // More pending only follows a forwarded departure.
    a_more_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.more_pending) |-> rsp.was_forwarded)
        else $error("more_pending without a forward");

    // The count moves only when an item is processed or the queue is flushed.
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(s1_adv) && !$past(cfg.flush)) |-> $stable(count_reg))
        else $error("queue count changed without an item");

endmodule
